FILE: src/sqsvf_pkg.sv
// Shared constants, types and helpers for the square-wave state-variable-filter synth.
package sqsvf_pkg;

    localparam int PHASE_STEP = 4;
    localparam int FRAC_BITS  = 16;

    localparam int PHASE_W = 16;
    localparam int STATE_W = 32;
    localparam int OPB_W   = 34;
    localparam int PROD_W  = 51;
    localparam int Y_W     = 35;
    localparam int YC_W    = FRAC_BITS + 2;
    localparam int SC_W    = YC_W + 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [15:0] CUT_RESET = 16'd2621;
    localparam logic [15:0] C15       = 16'd9830;
    localparam logic [15:0] C06       = 16'd3932;
    localparam logic [15:0] SCALE     = 16'd32767;
    localparam logic [16:0] BIAS_CONE  = 17'd16;
    localparam logic [16:0] BIAS_PIEZO = 17'd64;

    localparam logic signed [OPB_W-1:0] ONE_B = OPB_W'(1) << FRAC_BITS;
    localparam logic signed [Y_W-1:0]   ONE_Y = Y_W'(1) << FRAC_BITS;

    localparam logic [IDX_W-1:0] REG_SPEAKER_TYPE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MUTE         = 2'd1;
    localparam logic [IDX_W-1:0] REG_CUT          = 2'd2;
    localparam logic [IDX_W-1:0] REG_RESONANCE    = 2'd3;

    localparam logic [2:0] MUL_CUT_BD   = 3'd0;
    localparam logic [2:0] MUL_RES_BD   = 3'd1;
    localparam logic [2:0] MUL_CUT_DIFF = 3'd2;
    localparam logic [2:0] MUL_C15_BD   = 3'd3;
    localparam logic [2:0] MUL_C06_XLO  = 3'd4;

    typedef struct packed {
        logic       ld_in;
        logic       ld_phase;
        logic [2:0] mul_sel;
        logic       ld_prod;
        logic       ld_lo;
        logic       ld_damp;
        logic       ld_bd;
        logic       ld_t;
        logic       ld_y_cone;
        logic       ld_y_piezo;
        logic       ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic enable;
        logic piezo;
    } dp_stat_t;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [STATE_W+3:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > $signed(36'h07FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (v < $signed(36'hF80000000))
            r = 32'sh80000000;
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

endpackage

FILE: src/speaker_square_svf_synth_top.sv
// Top level of the square-wave tone source with two-state speaker filter.
//
// Input stream s_axis: one request per sample tick; tdata carries the timer
// period and the enable flag, tlast marks the last sample of a host buffer.
// Output stream m_axis: one signed 16-bit sample per request, tlast copied.
// Config channel cfg_*: index 0 speaker type, 1 mute, 2 cut, 3 resonance;
// always ready; written only while no request is in flight (user rule, unchecked).
// Timing: one request is in work at a time; the next is taken once the
// previous sample is in the output register. The sequencer steps one
// multiply at a time through a single shared 16 x 34 multiplier; a
// disabled request skips the multiplies and goes straight to the output.
// Reset: phase and filter state clear, registers return to defaults.
// A stalled receiver holds the sample in the output register; the block
// finishes the next request and waits with it until the register frees.
module speaker_square_svf_synth_top
    import sqsvf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // [15:0] period, [16] enable, rest zero
    input  logic             s_axis_tlast,   // block_end
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample
    output logic             m_axis_tlast,   // block_end_out
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [15:0] sample;

    assign cfg_ready = 1'b1;

    sqsvf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sqsvf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_idx       (cfg_index),
        .cfg_wdata     (cfg_data),
        .period        (s_axis_tdata[15:0]),
        .enable        (s_axis_tdata[16]),
        .block_end     (s_axis_tlast),
        .sample        (sample),
        .block_end_out (m_axis_tlast)
    );

    assign m_axis_tdata = sample;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a request is still in work");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("sample outside the clipped range");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

endmodule

FILE: src/sqsvf_ctrl.sv
// Sequencer: steps one sample through phase update, filter multiplies and output load.
module sqsvf_ctrl
    import sqsvf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PHASE = 4'd1;
    localparam logic [3:0] ST_M1    = 4'd2;
    localparam logic [3:0] ST_A1    = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_A2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_A3    = 4'd7;
    localparam logic [3:0] ST_M4    = 4'd8;
    localparam logic [3:0] ST_A4    = 4'd9;
    localparam logic [3:0] ST_M5    = 4'd10;
    localparam logic [3:0] ST_A5    = 4'd11;
    localparam logic [3:0] ST_CONEY = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_CUT_BD;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (stat.enable)
                begin
                    cmd.ld_phase = 1'b1;
                    state_next   = ST_M1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_M1:
            begin
                cmd.mul_sel = MUL_CUT_BD;
                cmd.ld_prod = 1'b1;
                state_next  = ST_A1;
            end
            ST_A1:
            begin
                cmd.ld_lo  = 1'b1;
                state_next = stat.piezo ? ST_M2 : ST_M3;
            end
            ST_M2:
            begin
                cmd.mul_sel = MUL_RES_BD;
                cmd.ld_prod = 1'b1;
                state_next  = ST_A2;
            end
            ST_A2:
            begin
                cmd.ld_damp = 1'b1;
                state_next  = ST_M3;
            end
            ST_M3:
            begin
                cmd.mul_sel = MUL_CUT_DIFF;
                cmd.ld_prod = 1'b1;
                state_next  = ST_A3;
            end
            ST_A3:
            begin
                cmd.ld_bd  = 1'b1;
                state_next = stat.piezo ? ST_M4 : ST_CONEY;
            end
            ST_M4:
            begin
                cmd.mul_sel = MUL_C15_BD;
                cmd.ld_prod = 1'b1;
                state_next  = ST_A4;
            end
            ST_A4:
            begin
                cmd.ld_t   = 1'b1;
                state_next = ST_M5;
            end
            ST_M5:
            begin
                cmd.mul_sel = MUL_C06_XLO;
                cmd.ld_prod = 1'b1;
                state_next  = ST_A5;
            end
            ST_A5:
            begin
                cmd.ld_y_piezo = 1'b1;
                state_next     = ST_OUT;
            end
            ST_CONEY:
            begin
                cmd.ld_y_cone = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/sqsvf_dp.sv
// Datapath: config registers, phase counter, shared multiplier, filter state, output register.
module sqsvf_dp
    import sqsvf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_idx,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic [PHASE_W-1:0] period,
    input  logic               enable,
    input  logic               block_end,
    output logic signed [15:0] sample,
    output logic               block_end_out
);

    logic                      speaker_type_reg;
    logic                      mute_reg;
    logic [15:0]               cut_reg;
    logic [15:0]               resonance_reg;

    logic [PHASE_W-1:0]        period_reg;
    logic                      enable_reg;
    logic                      blk_reg;

    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W-1:0]        phase_next;
    logic                      x_reg;
    logic                      x_next;
    logic signed [STATE_W-1:0] lo_reg;
    logic signed [STATE_W-1:0] lo_next;
    logic signed [STATE_W-1:0] bd_reg;
    logic signed [STATE_W-1:0] bd_next;
    logic signed [STATE_W-1:0] damp_reg;
    logic signed [STATE_W-1:0] t_reg;
    logic signed [Y_W-1:0]     y_reg;
    logic signed [Y_W-1:0]     y_cone_next;
    logic signed [Y_W-1:0]     y_piezo_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [15:0]        sample_reg;
    logic signed [15:0]        sample_next;
    logic                      blk_out_reg;

    logic signed [17:0]        pos_a;
    logic signed [17:0]        pos_w;
    logic signed [17:0]        per_s;
    logic [16:0]               thr;

    logic signed [OPB_W-1:0]   x_val;
    logic signed [OPB_W-1:0]   lo_b;
    logic signed [OPB_W-1:0]   bd_b;
    logic signed [OPB_W-1:0]   damp_b;
    logic signed [OPB_W-1:0]   diff;
    logic signed [OPB_W-1:0]   xlo;
    logic [15:0]               op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [STATE_W+3:0] prod_hi;

    logic signed [STATE_W:0]   sum_lb;
    logic signed [Y_W-1:0]     sum3;
    logic signed [YC_W-1:0]    yc;
    logic signed [SC_W-1:0]    scaled;
    logic signed [SC_W-1:0]    mag;

    assign stat.enable = enable_reg;
    assign stat.piezo  = speaker_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speaker_type_reg <= 1'b0;
            mute_reg         <= 1'b0;
            cut_reg          <= CUT_RESET;
            resonance_reg    <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SPEAKER_TYPE: speaker_type_reg <= cfg_wdata[0];
                REG_MUTE:         mute_reg         <= cfg_wdata[0];
                REG_CUT:          cut_reg          <= cfg_wdata;
                REG_RESONANCE:    resonance_reg    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // phase step, clip, wrap and square-wave compare
    always_comb
    begin
        per_s = $signed({2'b00, period_reg});
        pos_a = $signed({2'b00, phase_reg}) - $signed(18'(PHASE_STEP));
        if (pos_a > per_s)
            pos_a = per_s;
        pos_w = pos_a;
        if (pos_w < 0)
        begin
            if (period_reg == '0)
                pos_w = 18'sd1;
            else
            begin
                for (int i = 0; i < PHASE_STEP; i++)
                begin
                    if (pos_w < 0)
                        pos_w = pos_w + per_s;
                end
            end
        end
        phase_next = pos_w[PHASE_W-1:0];
        thr = ({1'b0, period_reg} + (speaker_type_reg ? BIAS_PIEZO : BIAS_CONE)) >> 1;
        x_next = (pos_w > $signed({1'b0, thr})) && !mute_reg;
    end

    // shared multiplier
    assign x_val  = x_reg ? ONE_B : '0;
    assign lo_b   = OPB_W'(lo_reg);
    assign bd_b   = OPB_W'(bd_reg);
    assign damp_b = OPB_W'(damp_reg);
    assign diff   = x_val - lo_b - (speaker_type_reg ? damp_b : bd_b);
    assign xlo    = x_val - lo_b;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_CUT_BD:   begin op_a = cut_reg;       op_b = bd_b;  end
            MUL_RES_BD:   begin op_a = resonance_reg; op_b = bd_b;  end
            MUL_CUT_DIFF: begin op_a = cut_reg;       op_b = diff;  end
            MUL_C15_BD:   begin op_a = C15;           op_b = bd_b;  end
            MUL_C06_XLO:  begin op_a = C06;           op_b = xlo;   end
            default:      begin op_a = '0;            op_b = '0;    end
        endcase
    end

    assign prod_next = $signed({1'b0, op_a}) * op_b;
    assign prod_hi   = (STATE_W+4)'($signed(prod_reg[PROD_W-1:16]));

    assign lo_next = sat32((STATE_W+4)'(lo_reg) + prod_hi);
    assign bd_next = sat32((STATE_W+4)'(bd_reg) + prod_hi);

    assign sum_lb       = (STATE_W+1)'(lo_reg) + (STATE_W+1)'(bd_reg);
    assign sum3         = Y_W'(sum_lb) + (Y_W'(sum_lb) <<< 1);
    assign y_cone_next  = sum3 >>> 2;
    assign y_piezo_next = Y_W'(t_reg) - Y_W'(prod_hi);

    // clip to +-1.0, scale, truncate toward zero; zero when disabled
    always_comb
    begin
        if (y_reg > ONE_Y)
            yc = YC_W'(ONE_Y);
        else if (y_reg < -ONE_Y)
            yc = YC_W'(-ONE_Y);
        else
            yc = y_reg[YC_W-1:0];
        scaled = SC_W'(yc) * $signed({1'b0, SCALE});
        mag    = -scaled;
        if (scaled < 0)
            sample_next = 16'(-(mag >>> FRAC_BITS));
        else
            sample_next = 16'(scaled >>> FRAC_BITS);
        if (!enable_reg)
            sample_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lo_reg    <= '0;
            bd_reg    <= '0;
        end
        else
        begin
            if (cmd.ld_phase)
                phase_reg <= phase_next;
            if (cmd.ld_lo)
                lo_reg <= lo_next;
            if (cmd.ld_bd)
                bd_reg <= bd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            period_reg <= period;
            enable_reg <= enable;
            blk_reg    <= block_end;
        end
        if (cmd.ld_phase)
            x_reg <= x_next;
        if (cmd.ld_prod)
            prod_reg <= prod_next;
        if (cmd.ld_damp)
            damp_reg <= prod_reg[47:16];
        if (cmd.ld_t)
            t_reg <= prod_reg[47:16];
        if (cmd.ld_y_cone)
            y_reg <= y_cone_next;
        else if (cmd.ld_y_piezo)
            y_reg <= y_piezo_next;
        if (cmd.ld_out)
        begin
            sample_reg  <= sample_next;
            blk_out_reg <= blk_reg;
        end
    end

    assign sample        = sample_reg;
    assign block_end_out = blk_out_reg;

endmodule
